/* src/ghp_pkg.sv */
package ghp_pkg;

    localparam int SLOTS      = 1024;
    localparam int FREE_DEPTH = 256;

    localparam int SLOT_AW  = $clog2(SLOTS);
    localparam int STACK_AW = $clog2(FREE_DEPTH);
    localparam int LIM_W    = 11;
    localparam int DEPTH_W  = 9;
    localparam int GEN_W    = 16;
    localparam int IDX_W    = 16;
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_RESOLVE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    localparam logic CFG_SLOT_LIMIT = 1'b0;
    localparam logic CFG_FREE_LIMIT = 1'b1;

    localparam logic [LIM_W-1:0]   SLOT_LIMIT_RST = 11'd1024;
    localparam logic [DEPTH_W-1:0] FREE_LIMIT_RST = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             occ;
        logic [GEN_W-1:0] gen;
    } slot_entry_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        slot_entry_t        wdata;
        logic [SLOT_AW-1:0] raddr;
    } slot_req_t;

    typedef struct packed {
        logic                we;
        logic [STACK_AW-1:0] waddr;
        logic [SLOT_AW-1:0]  wdata;
        logic [STACK_AW-1:0] raddr;
    } stack_req_t;

    typedef struct packed {
        logic               ok;
        logic [SLOT_AW-1:0] slot_index;
        logic [GEN_W-1:0]   slot_generation;
    } result_t;

endpackage

/* src/generational_handle_pool_top.sv */
// Generational handle pool: hands out slot indices with a 16-bit generation.
// s_ channel: one beat per operation (alloc, free, resolve, lookup, clear).
// m_ channel: exactly one result beat per operation, in order.
// cfg_ channel: register writes (0 slot_limit, 1 free_limit), always ready;
// write only while the pool is idle.
// Steps per operation, from accept to result register:
//   free / resolve / lookup / unused code: slot table read, then update
//   alloc from the recycled stack: stack read, slot read, update
//   alloc by scan: a slot read and a check per probed slot, plus a wrap-round
//     step and a final step when no slot is free;
//     one slot table port sets this walk
//   clear: every slot table entry zeroed, one per cycle
// Reset runs the same clearing pass; s_tready stays low until it
// is done and no result is sent for it. The next operation is accepted while
// a result waits in the output register; if the receiver still holds m_tready
// low when the following result is ready, the pool holds that result and
// takes no new beat until the output register drains.
module generational_handle_pool_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[2:0], index[18:3], generation[34:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ok[0], slot_index[10:1], slot_generation[26:11]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    import ghp_pkg::*;

    logic [LIM_W-1:0]   slot_limit_reg, slot_limit_next;
    logic [DEPTH_W-1:0] free_limit_reg, free_limit_next;
    logic               m_tvalid_reg, m_tvalid_next;
    result_t            out_reg, out_next;

    logic               out_free;
    logic               res_valid;
    result_t            res;
    slot_req_t          slot_req;
    slot_entry_t        slot_rdata;
    stack_req_t         stack_req;
    logic [SLOT_AW-1:0] stack_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        slot_limit_next = slot_limit_reg;
        free_limit_next = free_limit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLOT_LIMIT: slot_limit_next = cfg_data;
                CFG_FREE_LIMIT: free_limit_next = cfg_data[DEPTH_W-1:0];
                default:        slot_limit_next = slot_limit_reg;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg <= SLOT_LIMIT_RST;
            free_limit_reg <= FREE_LIMIT_RST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            slot_limit_reg <= slot_limit_next;
            free_limit_reg <= free_limit_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.slot_generation, out_reg.slot_index, out_reg.ok};

    ghp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tdata[2:0]),
        .in_index    (s_tdata[18:3]),
        .in_gen      (s_tdata[34:19]),
        .slot_limit  (slot_limit_reg),
        .free_limit  (free_limit_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .slot_req    (slot_req),
        .slot_rdata  (slot_rdata),
        .stack_req   (stack_req),
        .stack_rdata (stack_rdata)
    );

    ghp_slot_mem u_slot_mem (
        .aclk  (aclk),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    ghp_stack_mem u_stack_mem (
        .aclk  (aclk),
        .req   (stack_req),
        .rdata (stack_rdata)
    );

endmodule

/* src/ghp_slot_mem.sv */
module ghp_slot_mem (
    input  logic                 aclk,
    input  ghp_pkg::slot_req_t   req,
    output ghp_pkg::slot_entry_t rdata
);
    import ghp_pkg::*;

    slot_entry_t mem [SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ghp_stack_mem.sv */
module ghp_stack_mem (
    input  logic                         aclk,
    input  ghp_pkg::stack_req_t          req,
    output logic [ghp_pkg::SLOT_AW-1:0]  rdata
);
    import ghp_pkg::*;

    logic [SLOT_AW-1:0] mem [FREE_DEPTH];
    logic [SLOT_AW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ghp_ctrl.sv */
module ghp_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ghp_pkg::OP_W-1:0]      in_op,
    input  logic [ghp_pkg::IDX_W-1:0]     in_index,
    input  logic [ghp_pkg::GEN_W-1:0]     in_gen,
    input  logic [ghp_pkg::LIM_W-1:0]     slot_limit,
    input  logic [ghp_pkg::DEPTH_W-1:0]   free_limit,
    input  logic                          out_free,
    output logic                          res_valid,
    output ghp_pkg::result_t              res,
    output ghp_pkg::slot_req_t            slot_req,
    input  ghp_pkg::slot_entry_t          slot_rdata,
    output ghp_pkg::stack_req_t           stack_req,
    input  logic [ghp_pkg::SLOT_AW-1:0]   stack_rdata
);
    import ghp_pkg::*;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic [SLOT_AW-1:0]  slot_reg, slot_next;
    logic [LIM_W-1:0]    cur_reg, cur_next;
    logic                phase_reg, phase_next;
    logic [LIM_W-1:0]    scan_start_reg, scan_start_next;
    logic [DEPTH_W-1:0]  count_reg, count_next;
    logic [SLOT_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                clr_resp_reg, clr_resp_next;
    result_t             hold_reg, hold_next;

    logic [LIM_W-1:0]    lim;
    logic [DEPTH_W-1:0]  eff_depth;
    logic                accept;
    logic                idx_live;
    logic                gen_match;
    logic [GEN_W-1:0]    alloc_gen;
    logic [GEN_W-1:0]    gen_plus;
    logic [GEN_W-1:0]    bumped_gen;
    logic                pop_ok;
    logic                clr_last;
    logic                scan_issue;
    logic                scan_wrap;
    logic                scan_hit;
    logic                fin;
    result_t             fin_res;

    assign lim       = (slot_limit > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : slot_limit;
    assign eff_depth = (free_limit > DEPTH_W'(FREE_DEPTH)) ? DEPTH_W'(FREE_DEPTH) : free_limit;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    assign idx_live  = (idx_reg != '0) && (idx_reg < {{(IDX_W-LIM_W){1'b0}}, lim})
                       && slot_rdata.occ;
    assign gen_match = (slot_rdata.gen == gen_reg);
    assign alloc_gen = (slot_rdata.gen == '0) ? GEN_W'(1) : slot_rdata.gen;
    assign gen_plus  = gen_reg + GEN_W'(1);
    // generation 0 is never handed out
    assign bumped_gen = (gen_plus == '0) ? GEN_W'(1) : gen_plus;

    assign pop_ok   = (stack_rdata != '0) && ({1'b0, stack_rdata} < lim);
    assign clr_last = (clr_cnt_reg == SLOT_AW'(SLOTS - 1));
    assign scan_hit = !slot_rdata.occ && (cur_reg != '0);

    // first pass walks scan_start .. lim-1, second pass 1 .. scan_start-1
    always_comb begin
        scan_issue = 1'b0;
        scan_wrap  = 1'b0;
        if (!phase_reg) begin
            if (cur_reg < lim) begin
                scan_issue = 1'b1;
            end else begin
                scan_wrap = 1'b1;
            end
        end else if ((cur_reg < scan_start_reg) && (cur_reg < lim)) begin
            scan_issue = 1'b1;
        end
    end

    // completion of an item and its result
    always_comb begin
        fin     = 1'b0;
        fin_res = '0;
        unique case (state_reg)
            ST_EXEC: begin
                fin = 1'b1;
                unique case (op_reg)
                    OP_ALLOC: begin
                        fin_res = '{ok: 1'b1, slot_index: slot_reg, slot_generation: alloc_gen};
                    end
                    OP_FREE: begin
                        fin_res.ok = idx_live && gen_match;
                    end
                    OP_RESOLVE: begin
                        if (idx_live && gen_match) begin
                            fin_res = '{ok: 1'b1, slot_index: idx_reg[SLOT_AW-1:0],
                                        slot_generation: slot_rdata.gen};
                        end
                    end
                    OP_LOOKUP: begin
                        if (idx_live) begin
                            fin_res = '{ok: 1'b1, slot_index: idx_reg[SLOT_AW-1:0],
                                        slot_generation: slot_rdata.gen};
                        end
                    end
                    default: begin
                        fin_res = '0;
                    end
                endcase
            end
            ST_POP: begin
                fin = !pop_ok;
            end
            ST_SCAN: begin
                fin = !scan_issue && !scan_wrap;
            end
            ST_SCAN_CHK: begin
                fin = scan_hit;
                if (scan_hit) begin
                    fin_res = '{ok: 1'b1, slot_index: cur_reg[SLOT_AW-1:0],
                                slot_generation: alloc_gen};
                end
            end
            ST_CLEAR: begin
                fin        = clr_last && clr_resp_reg;
                fin_res.ok = 1'b1;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_ALLOC: state_next = (count_reg != '0) ? ST_POP : ST_SCAN;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_EXEC;
                    endcase
                end
            end
            ST_POP:      state_next = ST_EXEC;
            ST_SCAN:     state_next = scan_issue ? ST_SCAN_CHK : ST_SCAN;
            ST_SCAN_CHK: state_next = ST_SCAN;
            ST_CLEAR:    state_next = clr_last ? ST_IDLE : ST_CLEAR;
            ST_RESP:     state_next = out_free ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
        if (fin) begin
            state_next = out_free ? ST_IDLE : ST_RESP;
        end
    end

    always_comb begin
        op_next         = op_reg;
        idx_next        = idx_reg;
        gen_next        = gen_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        phase_next      = phase_reg;
        scan_start_next = scan_start_reg;
        count_next      = count_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_resp_next   = clr_resp_reg;
        hold_next       = hold_reg;
        res_valid       = 1'b0;
        res             = fin_res;
        slot_req        = '{we: 1'b0, waddr: '0, wdata: '0, raddr: in_index[SLOT_AW-1:0]};
        stack_req       = '{we: 1'b0, waddr: '0, wdata: '0,
                            raddr: STACK_AW'(count_reg - DEPTH_W'(1))};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next  = in_op;
                    idx_next = in_index;
                    gen_next = in_gen;
                    if (in_op == OP_ALLOC) begin
                        if (count_reg != '0) begin
                            count_next = count_reg - DEPTH_W'(1);
                        end else begin
                            cur_next   = scan_start_reg;
                            phase_next = 1'b0;
                        end
                    end else if (in_op == OP_CLEAR) begin
                        clr_cnt_next    = '0;
                        clr_resp_next   = 1'b1;
                        count_next      = '0;
                        scan_start_next = LIM_W'(1);
                    end
                end
            end
            ST_POP: begin
                slot_req.raddr = stack_rdata;
                slot_next      = stack_rdata;
            end
            ST_EXEC: begin
                if (op_reg == OP_ALLOC) begin
                    slot_req.we    = 1'b1;
                    slot_req.waddr = slot_reg;
                    slot_req.wdata = '{occ: 1'b1, gen: alloc_gen};
                end else if ((op_reg == OP_FREE) && idx_live && gen_match) begin
                    slot_req.we    = 1'b1;
                    slot_req.waddr = idx_reg[SLOT_AW-1:0];
                    slot_req.wdata = '{occ: 1'b0, gen: bumped_gen};
                    if (count_reg < eff_depth) begin
                        stack_req.we    = 1'b1;
                        stack_req.waddr = count_reg[STACK_AW-1:0];
                        stack_req.wdata = idx_reg[SLOT_AW-1:0];
                        count_next      = count_reg + DEPTH_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                slot_req.raddr = cur_reg[SLOT_AW-1:0];
                if (scan_wrap) begin
                    phase_next = 1'b1;
                    cur_next   = LIM_W'(1);
                end
            end
            ST_SCAN_CHK: begin
                if (scan_hit) begin
                    slot_req.we     = 1'b1;
                    slot_req.waddr  = cur_reg[SLOT_AW-1:0];
                    slot_req.wdata  = '{occ: 1'b1, gen: alloc_gen};
                    scan_start_next = cur_reg + LIM_W'(1);
                end else begin
                    cur_next = cur_reg + LIM_W'(1);
                end
            end
            ST_CLEAR: begin
                slot_req.we    = 1'b1;
                slot_req.waddr = clr_cnt_reg;
                slot_req.wdata = '0;
                clr_cnt_next   = clr_cnt_reg + SLOT_AW'(1);
            end
            ST_RESP: begin
                res_valid = out_free;
                res       = hold_reg;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        if (fin) begin
            res_valid = out_free;
            hold_next = fin_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            count_reg      <= '0;
            scan_start_reg <= LIM_W'(1);
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_resp_reg   <= clr_resp_next;
            count_reg      <= count_next;
            scan_start_reg <= scan_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        gen_reg   <= gen_next;
        slot_reg  <= slot_next;
        cur_reg   <= cur_next;
        phase_reg <= phase_next;
        hold_reg  <= hold_next;
    end

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghp_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam int IDLE_LIMIT     = 10000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 85;
    localparam int RECYCLE_ROUNDS = 16;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // op[2:0], index[18:3], generation[34:19]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // ok[0], slot_index[10:1], slot_generation[26:11]
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [10:0] cfg_data;

    generational_handle_pool_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the pool
    bit                 slot_busy [SLOTS];
    bit [GEN_W-1:0]     slot_gen [SLOTS];
    bit [SLOT_AW-1:0]   recycle_stack [FREE_DEPTH];
    int                 recycle_cnt = 0;
    bit [LIM_W-1:0]     scan_ptr = 1;
    bit [LIM_W-1:0]     cfg_slot_limit = SLOT_LIMIT_RST;
    bit [DEPTH_W-1:0]   cfg_free_limit = FREE_LIMIT_RST;

    result_t expected_results [$];
    int      fail_count = 0;
    int      n_results = 0;
    int      idle_cycles = 0;
    int      tx_idle_pct = 30;
    int      rx_idle_pct = 30;
    bit      rx_long_hold = 1'b0;

    function automatic int eff_slot_limit();
        return (cfg_slot_limit < SLOTS) ? int'(cfg_slot_limit) : SLOTS;
    endfunction

    // recycled slot first, then roving scan with wrap to slot 1; 0 means none
    function automatic int claim_slot(int lim);
        if (recycle_cnt > 0) begin
            recycle_cnt--;
            return recycle_stack[recycle_cnt];
        end
        for (int i = scan_ptr; i < lim; i++) begin
            if (i != 0 && !slot_busy[i]) begin
                scan_ptr = LIM_W'(i + 1);
                return i;
            end
        end
        for (int i = 1; i < scan_ptr && i < lim; i++) begin
            if (!slot_busy[i]) begin
                scan_ptr = LIM_W'(i + 1);
                return i;
            end
        end
        return 0;
    endfunction

    function automatic result_t pool_apply(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                           logic [GEN_W-1:0] gen);
        result_t          r;
        int               lim;
        int               depth;
        int               s;
        bit               live;
        logic [GEN_W-1:0] g;
        r     = '0;
        lim   = eff_slot_limit();
        depth = (cfg_free_limit < FREE_DEPTH) ? int'(cfg_free_limit) : FREE_DEPTH;
        live  = (idx != 0) && (idx < lim) && slot_busy[idx];
        case (op)
            OP_ALLOC: begin
                s = claim_slot(lim);
                if (s != 0 && s < lim) begin
                    if (slot_gen[s] == '0) begin
                        slot_gen[s] = 1;
                    end
                    slot_busy[s]      = 1'b1;
                    r.ok              = 1'b1;
                    r.slot_index      = SLOT_AW'(s);
                    r.slot_generation = slot_gen[s];
                end
            end
            OP_FREE: begin
                if (live && slot_gen[idx] == gen) begin
                    g = gen + 1'b1;
                    if (g == '0) begin
                        g = 1;
                    end
                    slot_busy[idx] = 1'b0;
                    slot_gen[idx]  = g;
                    if (recycle_cnt < depth) begin
                        recycle_stack[recycle_cnt] = idx[SLOT_AW-1:0];
                        recycle_cnt++;
                    end
                    r.ok = 1'b1;
                end
            end
            OP_RESOLVE, OP_LOOKUP: begin
                if (live && (op == OP_LOOKUP || slot_gen[idx] == gen)) begin
                    r.ok              = 1'b1;
                    r.slot_index      = idx[SLOT_AW-1:0];
                    r.slot_generation = slot_gen[idx];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_busy[i] = 1'b0;
                    slot_gen[i]  = '0;
                end
                recycle_cnt = 0;
                scan_ptr    = 1;
                r.ok        = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(60, 20);
        end
        return $urandom_range(3, 1);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {5'b0, gen, idx, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(pool_apply(op, idx, gen));
        @(negedge aclk);
    endtask

    task automatic drain_pool();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // both registers, valid held across the two beats
    task automatic configure(int slots, int depth);
        drain_pool();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SLOT_LIMIT;
        cfg_data  <= LIM_W'(slots);
        do @(posedge aclk); while (!cfg_ready);
        cfg_slot_limit = LIM_W'(slots);
        @(negedge aclk);
        cfg_index <= CFG_FREE_LIMIT;
        cfg_data  <= LIM_W'(depth);
        do @(posedge aclk); while (!cfg_ready);
        cfg_free_limit = DEPTH_W'(depth);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_op();
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        int               lim;
        int               roll;
        int               pick;
        int               live [$];
        lim  = eff_slot_limit();
        roll = $urandom_range(99);
        if (roll < 38) begin
            op = OP_ALLOC;
        end else if (roll < 66) begin
            op = OP_FREE;
        end else if (roll < 80) begin
            op = OP_RESOLVE;
        end else if (roll < 93) begin
            op = OP_LOOKUP;
        end else if (roll < 94) begin
            op = OP_CLEAR;
        end else begin
            op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        end
        for (int i = 1; i < lim; i++) begin
            if (slot_busy[i]) begin
                live.push_back(i);
            end
        end
        pick = $urandom_range(99);
        if (pick < 70 && live.size() > 0) begin
            idx = IDX_W'(live[$urandom_range(live.size() - 1)]);
            gen = slot_gen[idx];
            if ($urandom_range(9) == 0) begin
                gen = gen ^ (16'h1 << $urandom_range(15));
            end
        end else if (pick < 85) begin
            idx = IDX_W'($urandom_range(lim));
            gen = (idx < SLOTS) ? slot_gen[idx] : '0;
        end else begin
            idx = IDX_W'($urandom);
            gen = GEN_W'($urandom);
        end
        send_op(op, idx, gen);
    endtask

    task automatic test_basic_ops();
        send_op(OP_LOOKUP, 0, 0);
        send_op(OP_RESOLVE, 16'hFFFF, 16'hFFFF);
        send_op(OP_LOOKUP, 5, 0);
        send_op(OP_RSVD_FIRST, 16'hFFFF, 16'hFFFF);
        send_op(OP_RSVD_LAST, 0, 0);
        repeat (3) send_op(OP_ALLOC, 0, 0);
        send_op(OP_RESOLVE, 1, 1);
        send_op(OP_RESOLVE, 1, 2);
        send_op(OP_FREE, 2, 1);
        send_op(OP_FREE, 2, 2);
        send_op(OP_ALLOC, 16'hFFFF, 16'hFFFF);
        send_op(OP_LOOKUP, 2, 16'hFFFF);
        send_op(OP_FREE, 3, 0);
        send_op(OP_CLEAR, 16'hFFFF, 0);
        send_op(OP_LOOKUP, 1, 0);
        send_op(OP_ALLOC, 0, 0);
    endtask

    task automatic test_scan_and_capacity();
        // no valid index at all
        configure(1, FREE_DEPTH);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_LOOKUP, 1, 0);
        send_op(OP_FREE, 1, 1);
        // tiny pool, no recycling: fill, fail, then find a freed slot by wrapping
        configure(4, 0);
        send_op(OP_CLEAR, 0, 0);
        repeat (4) send_op(OP_ALLOC, 0, 0);
        send_op(OP_FREE, 2, 1);
        send_op(OP_ALLOC, 0, 0);
        // stale stack entries above a lowered limit, capacity below count
        configure(SLOTS, FREE_DEPTH);
        send_op(OP_CLEAR, 0, 0);
        repeat (10) send_op(OP_ALLOC, 0, 0);
        send_op(OP_FREE, 9, 1);
        send_op(OP_FREE, 3, 1);
        configure(SLOTS, 1);
        send_op(OP_FREE, 4, 1);
        configure(5, 1);
        repeat (3) send_op(OP_ALLOC, 0, 0);
        send_op(OP_LOOKUP, 9, 0);
    endtask

    // recycle one slot over and over; each free bumps its generation
    task automatic test_slot_recycle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_ALLOC, 0, 0);
        for (int k = 0; k < RECYCLE_ROUNDS; k++) begin
            send_op(OP_FREE, 1, slot_gen[1]);
            send_op(OP_ALLOC, 0, 0);
        end
        send_op(OP_RESOLVE, 1, slot_gen[1]);
        send_op(OP_RESOLVE, 1, 1);
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_long_hold = 1'b1;
        repeat (12) send_op(OP_LOOKUP, IDX_W'($urandom_range(4, 1)), 0);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: configure(16, 4);
                1: configure(8, 0);
                2: configure(64, 1);
                3: configure($urandom_range(SLOTS, 2), $urandom_range(FREE_DEPTH, 0));
                default: begin
                    configure(SLOTS, FREE_DEPTH);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) random_op();
        end
    endtask

    // result sink with random stalls and one long hold on request
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                stall = RX_HOLD_CYCLES;
            end else if (stall == 0) begin
                stall = pick_gap(rx_idle_pct);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t            want;
        logic               got_ok;
        logic [SLOT_AW-1:0] got_idx;
        logic [GEN_W-1:0]   got_gen;
        if (aresetn && m_tvalid && m_tready) begin
            got_ok  = m_tdata[0];
            got_idx = m_tdata[10:1];
            got_gen = m_tdata[26:11];
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("[%0t] result beat %0d with none pending: ok=%0b idx=%0d gen=%0d",
                             $realtime, n_results, got_ok, got_idx, got_gen);
                end
            end else begin
                want = expected_results.pop_front();
                if (got_ok !== want.ok || got_idx !== want.slot_index ||
                    got_gen !== want.slot_generation) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("[%0t] beat %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                                 $realtime, n_results, want.ok, want.slot_index,
                                 want.slot_generation, got_ok, got_idx, got_gen);
                    end
                end
            end
            n_results++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, IDLE_LIMIT);
            $display("** generational_handle_pool_top: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLOT_LIMIT;
        cfg_data  = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_ops();
        test_scan_and_capacity();
        test_slot_recycle();
        test_backpressure();
        test_random_mix();

        drain_pool();
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("** generational_handle_pool_top: PASSED **");
        end else begin
            $display("** generational_handle_pool_top: FAILED **");
        end
        $finish;
    end

endmodule
